// ===== sv/kmst_pkg.sv =====
// Shared types and constants for the spanning-tree block.
package kmst_pkg;

    // Field widths fixed by the item format
    localparam int NODE_PORT_W = 5;
    localparam int WEIGHT_PORT_W = 16;
    localparam int COST_W = 21;
    localparam int TNC_W = 6;
    localparam int TNC_RESET = 32;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Register indexes
    localparam logic REG_TREE_NODE_COUNT = 1'b0;

    // Union-find memory control
    typedef struct packed {
        logic clear;
        logic we;
    } uf_ctl_t;

endpackage

// ===== sv/kmst_edge_mem.sv =====
// Edge store: one write port, one registered read port.
module kmst_edge_mem #(
    parameter int DEPTH = 64,
    parameter int AW = 6,
    parameter int DW = 27
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // Write and synchronous read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/kmst_uf_mem.sv =====
// Union-find memory: parent link and set size per node, valid bits give reset value.
module kmst_uf_mem #(
    parameter int DEPTH = 32,
    parameter int AW = 5,
    parameter int SW = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  kmst_pkg::uf_ctl_t ctl,
    input  logic [AW-1:0]  waddr,
    input  logic [AW-1:0]  wparent,
    input  logic [SW-1:0]  wsize,
    input  logic [AW-1:0]  raddr,
    output logic [AW-1:0]  rparent,
    output logic [SW-1:0]  rsize
);
    import kmst_pkg::*;

    logic [AW+SW-1:0] mem [DEPTH];
    logic [AW+SW-1:0] q_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             rvalid_reg;
    logic [AW-1:0]    raddr_reg;

    // Storage and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= {wparent, wsize};
        end
        q_reg <= mem[raddr];
        raddr_reg <= raddr;
    end

    // Entry valid bits; invalid entry is a root of size one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            rvalid_reg <= valid_reg[raddr] && !ctl.clear;
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    assign rparent = rvalid_reg ? q_reg[AW+SW-1:SW] : raddr_reg;
    assign rsize = rvalid_reg ? q_reg[SW-1:0] : SW'(1);

endmodule

// ===== sv/kruskal_mst_union_find.sv =====
// Kruskal spanning tree over a loaded edge list, union-find in memory.
// Input channel (in_valid/in_stall): one beat per edge or clear command.
//   A load beat stores the edge while the store has room; beats are taken
//   back to back while no run is active. A load beat with final_edge set
//   starts a run; in_stall stays high until the run hands off its last result.
// Run: each selection checks the accepted count and sweeps the edge store,
//   one read per cycle, then walks parent links for both endpoints with path
//   compression, then the union (S_URA, S_URB, S_UCMP, S_UW2) and S_EMIT to
//   hold the result. Each accepted edge yields one result beat.
// Output channel (out_valid/out_stall): results leave from an output
//   register; a held-back result register delays each beat until it is known
//   whether it is the last. A stalled output holds its beat and the run
//   waits for the slot. An empty tree gives one beat with edge_valid low.
// Configuration: APB, register 0 is tree_node_count (reset 32); write only
//   while idle.
// Reset: asynchronous, active low; clears the edge count, the union-find
//   valid bits and all control state. No clearing pass is needed.
module kruskal_mst_union_find #(
    parameter int MAX_NODES = 32,
    parameter int MAX_EDGES = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [kmst_pkg::NODE_PORT_W-1:0]   end_node_a,
    input  logic [kmst_pkg::NODE_PORT_W-1:0]   end_node_b,
    input  logic [kmst_pkg::WEIGHT_PORT_W-1:0] edge_weight,
    input  logic        final_edge,
    // Output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        edge_valid,
    output logic [kmst_pkg::NODE_PORT_W-1:0]   tree_node_a,
    output logic [kmst_pkg::NODE_PORT_W-1:0]   tree_node_b,
    output logic [kmst_pkg::WEIGHT_PORT_W-1:0] tree_weight,
    output logic [kmst_pkg::COST_W-1:0]        running_cost,
    output logic        incomplete,
    output logic        last_result
);
    import kmst_pkg::*;

    localparam int NW = $clog2(MAX_NODES);
    localparam int SW = $clog2(MAX_NODES + 1);
    localparam int WB = (WEIGHT_BITS < WEIGHT_PORT_W) ? WEIGHT_BITS : WEIGHT_PORT_W;
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int EDW = 2 * NW + WB;
    localparam int TW = 9;

    // Sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_FRD   = 4'd3;
    localparam logic [3:0] S_FCHK  = 4'd4;
    localparam logic [3:0] S_CRD   = 4'd5;
    localparam logic [3:0] S_CWR   = 4'd6;
    localparam logic [3:0] S_URA   = 4'd7;
    localparam logic [3:0] S_URB   = 4'd8;
    localparam logic [3:0] S_UCMP  = 4'd9;
    localparam logic [3:0] S_UW2   = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;
    localparam logic [3:0] S_FIN   = 4'd12;

    // Node index reduced modulo MAX_NODES by constant long division
    function automatic logic [NW-1:0] node_idx(input logic [NODE_PORT_W-1:0] v);
        logic [NODE_PORT_W:0] r;
        r = {1'b0, v};
        for (int k = 4; k >= 0; k--)
        begin
            if (int'(r) >= (MAX_NODES << k))
            begin
                r = r - (NODE_PORT_W + 1)'(MAX_NODES << k);
            end
        end
        return NW'(r);
    endfunction

    // Registers
    logic [3:0]        state_reg, state_next;
    logic [TNC_W-1:0]  tnc_reg, tnc_next;
    logic [ECW-1:0]    ecount_reg, ecount_next;
    logic [ECW-1:0]    scan_reg, scan_next;
    logic              rvalid_reg, rvalid_next;
    logic [EAW-1:0]    raddr_d_reg, raddr_d_next;
    logic              found_reg, found_next;
    logic [EAW-1:0]    best_idx_reg, best_idx_next;
    logic [NW-1:0]     best_a_reg, best_a_next;
    logic [NW-1:0]     best_b_reg, best_b_next;
    logic [WB-1:0]     best_w_reg, best_w_next;
    logic [MAX_EDGES-1:0] used_reg, used_next;
    logic              which_reg, which_next;
    logic [NW-1:0]     start_reg, start_next;
    logic [NW-1:0]     cur_reg, cur_next;
    logic [NW-1:0]     root_reg, root_next;
    logic [NW-1:0]     ra_reg, ra_next;
    logic [NW-1:0]     rb_reg, rb_next;
    logic [SW-1:0]     size_a_reg, size_a_next;
    logic [NW-1:0]     win_reg, win_next;
    logic [SW-1:0]     sum_reg, sum_next;
    logic [COST_W-1:0] cost_reg, cost_next;
    logic [SW-1:0]     acc_reg, acc_next;
    logic              ran_out_reg, ran_out_next;
    logic              pend_have_reg, pend_have_next;
    logic [NW-1:0]     pend_a_reg, pend_a_next;
    logic [NW-1:0]     pend_b_reg, pend_b_next;
    logic [WB-1:0]     pend_w_reg, pend_w_next;
    logic [COST_W-1:0] pend_cost_reg, pend_cost_next;
    logic              ov_reg, ov_next;
    logic              oe_reg, oe_next;
    logic [NW-1:0]     oa_reg, oa_next;
    logic [NW-1:0]     ob_reg, ob_next;
    logic [WB-1:0]     ow_reg, ow_next;
    logic [COST_W-1:0] oc_reg, oc_next;
    logic              oi_reg, oi_next;
    logic              ol_reg, ol_next;

    // Memory ports
    logic              em_we;
    logic [EAW-1:0]    em_raddr;
    logic [EDW-1:0]    em_wdata, em_rdata;
    uf_ctl_t           uf_ctl;
    logic [NW-1:0]     uf_waddr, uf_wparent, uf_raddr, uf_rparent;
    logic [SW-1:0]     uf_wsize, uf_rsize;

    // Decoded values
    logic              in_fire, cfg_wr, out_free, find_done, take;
    logic [TW-1:0]     nodes, needed;
    logic [NW-1:0]     rd_a, rd_b, done_root;
    logic [WB-1:0]     rd_w;

    kmst_edge_mem #(.DEPTH(MAX_EDGES), .AW(EAW), .DW(EDW)) u_edge_mem (
        .clk   (clk),
        .we    (em_we),
        .waddr (ecount_reg[EAW-1:0]),
        .wdata (em_wdata),
        .raddr (em_raddr),
        .rdata (em_rdata)
    );

    kmst_uf_mem #(.DEPTH(MAX_NODES), .AW(NW), .SW(SW)) u_uf_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (uf_ctl),
        .waddr   (uf_waddr),
        .wparent (uf_wparent),
        .wsize   (uf_wsize),
        .raddr   (uf_raddr),
        .rparent (uf_rparent),
        .rsize   (uf_rsize)
    );

    // Handshakes and configuration
    assign in_stall = (state_reg != S_IDLE);
    assign in_fire = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TREE_NODE_COUNT) ? 32'(tnc_reg) : 32'd0;

    // Edge count target
    assign nodes = (TW'(tnc_reg) > TW'(MAX_NODES)) ? TW'(MAX_NODES) : TW'(tnc_reg);
    assign needed = (nodes == '0) ? '0 : nodes - TW'(1);

    // Edge store fields
    assign em_wdata = {node_idx(end_node_a), node_idx(end_node_b), edge_weight[WB-1:0]};
    assign rd_a = em_rdata[EDW-1 -: NW];
    assign rd_b = em_rdata[WB + NW - 1 -: NW];
    assign rd_w = em_rdata[WB-1:0];
    assign em_raddr = scan_reg[EAW-1:0];
    assign take = rvalid_reg && !used_reg[raddr_d_reg] && (!found_reg || rd_w < best_w_reg);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        tnc_next = tnc_reg;
        ecount_next = ecount_reg;
        scan_next = scan_reg;
        rvalid_next = 1'b0;
        raddr_d_next = scan_reg[EAW-1:0];
        found_next = found_reg;
        best_idx_next = best_idx_reg;
        best_a_next = best_a_reg;
        best_b_next = best_b_reg;
        best_w_next = best_w_reg;
        used_next = used_reg;
        which_next = which_reg;
        start_next = start_reg;
        cur_next = cur_reg;
        root_next = root_reg;
        ra_next = ra_reg;
        rb_next = rb_reg;
        size_a_next = size_a_reg;
        win_next = win_reg;
        sum_next = sum_reg;
        cost_next = cost_reg;
        acc_next = acc_reg;
        ran_out_next = ran_out_reg;
        pend_have_next = pend_have_reg;
        pend_a_next = pend_a_reg;
        pend_b_next = pend_b_reg;
        pend_w_next = pend_w_reg;
        pend_cost_next = pend_cost_reg;
        ov_next = ov_reg && out_stall;
        oe_next = oe_reg;
        oa_next = oa_reg;
        ob_next = ob_reg;
        ow_next = ow_reg;
        oc_next = oc_reg;
        oi_next = oi_reg;
        ol_next = ol_reg;
        em_we = 1'b0;
        uf_ctl = '0;
        uf_waddr = cur_reg;
        uf_wparent = root_reg;
        uf_wsize = uf_rsize;
        uf_raddr = cur_reg;
        find_done = 1'b0;
        done_root = root_reg;

        if (cfg_wr && paddr[2] == REG_TREE_NODE_COUNT)
        begin
            tnc_next = pwdata[TNC_W-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (operation == OP_CLEAR)
                    begin
                        ecount_next = '0;
                    end
                    else
                    begin
                        if (ecount_reg < ECW'(MAX_EDGES))
                        begin
                            em_we = 1'b1;
                            ecount_next = ecount_reg + ECW'(1);
                        end
                        if (final_edge)
                        begin
                            uf_ctl.clear = 1'b1;
                            used_next = '0;
                            cost_next = '0;
                            acc_next = '0;
                            ran_out_next = 1'b0;
                            pend_have_next = 1'b0;
                            state_next = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK:
            begin
                scan_next = '0;
                found_next = 1'b0;
                state_next = (TW'(acc_reg) >= needed) ? S_FIN : S_SCAN;
            end
            S_SCAN:
            begin
                // one read per cycle, compare the returned entry
                if (scan_reg < ecount_reg)
                begin
                    rvalid_next = 1'b1;
                    scan_next = scan_reg + ECW'(1);
                end
                if (take)
                begin
                    found_next = 1'b1;
                    best_idx_next = raddr_d_reg;
                    best_a_next = rd_a;
                    best_b_next = rd_b;
                    best_w_next = rd_w;
                end
                if (scan_reg == ecount_reg && !rvalid_reg)
                begin
                    if (found_reg)
                    begin
                        used_next[best_idx_reg] = 1'b1;
                        which_next = 1'b0;
                        start_next = best_a_reg;
                        cur_next = best_a_reg;
                        state_next = S_FRD;
                    end
                    else
                    begin
                        ran_out_next = 1'b1;
                        state_next = S_FIN;
                    end
                end
            end
            S_FRD:
            begin
                uf_raddr = cur_reg;
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                // follow the parent link until a root
                if (uf_rparent == cur_reg)
                begin
                    root_next = cur_reg;
                    if (start_reg == cur_reg)
                    begin
                        find_done = 1'b1;
                        done_root = cur_reg;
                    end
                    else
                    begin
                        cur_next = start_reg;
                        state_next = S_CRD;
                    end
                end
                else
                begin
                    cur_next = uf_rparent;
                    state_next = S_FRD;
                end
            end
            S_CRD:
            begin
                uf_raddr = cur_reg;
                state_next = S_CWR;
            end
            S_CWR:
            begin
                // path compression: point the node at the root
                uf_ctl.we = 1'b1;
                uf_waddr = cur_reg;
                uf_wparent = root_reg;
                uf_wsize = uf_rsize;
                cur_next = uf_rparent;
                if (uf_rparent == root_reg)
                begin
                    find_done = 1'b1;
                    done_root = root_reg;
                end
                else
                begin
                    state_next = S_CRD;
                end
            end
            S_URA:
            begin
                uf_raddr = ra_reg;
                state_next = S_URB;
            end
            S_URB:
            begin
                size_a_next = uf_rsize;
                uf_raddr = rb_reg;
                state_next = S_UCMP;
            end
            S_UCMP:
            begin
                // union by size, ties keep the first root
                uf_ctl.we = 1'b1;
                sum_next = size_a_reg + uf_rsize;
                if (size_a_reg < uf_rsize)
                begin
                    uf_waddr = ra_reg;
                    uf_wparent = rb_reg;
                    uf_wsize = size_a_reg;
                    win_next = rb_reg;
                end
                else
                begin
                    uf_waddr = rb_reg;
                    uf_wparent = ra_reg;
                    uf_wsize = uf_rsize;
                    win_next = ra_reg;
                end
                state_next = S_UW2;
            end
            S_UW2:
            begin
                uf_ctl.we = 1'b1;
                uf_waddr = win_reg;
                uf_wparent = win_reg;
                uf_wsize = sum_reg;
                cost_next = cost_reg + COST_W'(best_w_reg);
                acc_next = acc_reg + SW'(1);
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // push the held result out, hold the new one
                if (!pend_have_reg || out_free)
                begin
                    if (pend_have_reg)
                    begin
                        ov_next = 1'b1;
                        oe_next = 1'b1;
                        oa_next = pend_a_reg;
                        ob_next = pend_b_reg;
                        ow_next = pend_w_reg;
                        oc_next = pend_cost_reg;
                        oi_next = 1'b0;
                        ol_next = 1'b0;
                    end
                    pend_have_next = 1'b1;
                    pend_a_next = best_a_reg;
                    pend_b_next = best_b_reg;
                    pend_w_next = best_w_reg;
                    pend_cost_next = cost_reg;
                    state_next = S_CHECK;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    oe_next = pend_have_reg;
                    oa_next = pend_have_reg ? pend_a_reg : '0;
                    ob_next = pend_have_reg ? pend_b_reg : '0;
                    ow_next = pend_have_reg ? pend_w_reg : '0;
                    oc_next = pend_have_reg ? pend_cost_reg : '0;
                    oi_next = ran_out_reg;
                    ol_next = 1'b1;
                    pend_have_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of a find: second endpoint next, or go to union
        if (find_done)
        begin
            if (!which_reg)
            begin
                ra_next = done_root;
                which_next = 1'b1;
                start_next = best_b_reg;
                cur_next = best_b_reg;
                state_next = S_FRD;
            end
            else
            begin
                rb_next = done_root;
                state_next = (ra_reg == done_root) ? S_CHECK : S_URA;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tnc_reg <= TNC_W'(TNC_RESET);
            ecount_reg <= '0;
            scan_reg <= '0;
            rvalid_reg <= 1'b0;
            found_reg <= 1'b0;
            used_reg <= '0;
            which_reg <= 1'b0;
            cost_reg <= '0;
            acc_reg <= '0;
            ran_out_reg <= 1'b0;
            pend_have_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tnc_reg <= tnc_next;
            ecount_reg <= ecount_next;
            scan_reg <= scan_next;
            rvalid_reg <= rvalid_next;
            found_reg <= found_next;
            used_reg <= used_next;
            which_reg <= which_next;
            cost_reg <= cost_next;
            acc_reg <= acc_next;
            ran_out_reg <= ran_out_next;
            pend_have_reg <= pend_have_next;
            ov_reg <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        raddr_d_reg <= raddr_d_next;
        best_idx_reg <= best_idx_next;
        best_a_reg <= best_a_next;
        best_b_reg <= best_b_next;
        best_w_reg <= best_w_next;
        start_reg <= start_next;
        cur_reg <= cur_next;
        root_reg <= root_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        size_a_reg <= size_a_next;
        win_reg <= win_next;
        sum_reg <= sum_next;
        pend_a_reg <= pend_a_next;
        pend_b_reg <= pend_b_next;
        pend_w_reg <= pend_w_next;
        pend_cost_reg <= pend_cost_next;
        oe_reg <= oe_next;
        oa_reg <= oa_next;
        ob_reg <= ob_next;
        ow_reg <= ow_next;
        oc_reg <= oc_next;
        oi_reg <= oi_next;
        ol_reg <= ol_next;
    end

    // Output beat
    assign out_valid = ov_reg;
    assign edge_valid = oe_reg;
    assign tree_node_a = NODE_PORT_W'(oa_reg);
    assign tree_node_b = NODE_PORT_W'(ob_reg);
    assign tree_weight = WEIGHT_PORT_W'(ow_reg);
    assign running_cost = oc_reg;
    assign incomplete = oi_reg;
    assign last_result = ol_reg;

`ifndef SYNTH
    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !edge_valid |-> last_result)
        else $error("empty result not marked last");
    a_incomplete_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && incomplete |-> last_result)
        else $error("incomplete flag on a non-final result");
    a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> TW'(acc_reg) <= needed)
        else $error("accepted more edges than the tree needs");
    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && pend_have_reg && ov_reg && out_stall |=> state_reg == S_EMIT)
        else $error("held result overwrote a stalled beat");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the Kruskal spanning-tree block.
`timescale 1ns / 1ps

module tb_top;
    import kmst_pkg::*;

    localparam int NODES = 32;
    localparam int EDGE_SLOTS = 64;
    localparam int IDLE_LIMIT = 40000;

    typedef struct {
        logic                     op;
        logic [NODE_PORT_W-1:0]   a;
        logic [NODE_PORT_W-1:0]   b;
        logic [WEIGHT_PORT_W-1:0] w;
        logic                     fin;
    } edge_beat_t;

    typedef struct {
        logic                     valid;
        logic [NODE_PORT_W-1:0]   a;
        logic [NODE_PORT_W-1:0]   b;
        logic [WEIGHT_PORT_W-1:0] w;
        logic [COST_W-1:0]        cost;
        logic                     short_tree;
        logic                     last;
    } tree_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = OP_LOAD;
    logic [NODE_PORT_W-1:0] end_node_a = '0, end_node_b = '0;
    logic [WEIGHT_PORT_W-1:0] edge_weight = '0;
    logic final_edge = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic edge_valid, incomplete, last_result;
    logic [NODE_PORT_W-1:0] tree_node_a, tree_node_b;
    logic [WEIGHT_PORT_W-1:0] tree_weight;
    logic [COST_W-1:0] running_cost;

    kruskal_mst_union_find dut (.*);

    // Clock: 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Predictor state
    edge_beat_t edge_q[$];
    tree_beat_t tree_q[$];
    logic [NODE_PORT_W-1:0]   st_a [EDGE_SLOTS];
    logic [NODE_PORT_W-1:0]   st_b [EDGE_SLOTS];
    logic [WEIGHT_PORT_W-1:0] st_w [EDGE_SLOTS];
    bit                       st_used [EDGE_SLOTS];
    int                       st_count = 0;
    int                       link [NODES];
    int                       grp_size [NODES];
    logic [TNC_W-1:0]         tnc_shadow = TNC_W'(TNC_RESET);

    int  errors = 0;
    int  send_idle_pct = 10;
    int  recv_idle_pct = 51;
    int  hold_requests = 0;
    bit  in_taken = 1'b0;

    function automatic void uf_reset();
        for (int i = 0; i < NODES; i++)
        begin
            link[i] = i;
            grp_size[i] = 1;
        end
    endfunction

    function automatic int find_root(int x);
        int r, n, nxt, steps;
        r = x;
        n = x;
        steps = 0;
        while (link[r] != r && steps < NODES)
        begin
            r = link[r];
            steps++;
        end
        // path compression
        while (n != r)
        begin
            nxt = link[n];
            link[n] = r;
            n = nxt;
        end
        return r;
    endfunction

    // Work out the tree beats caused by one accepted edge beat
    function automatic void predict_tree(edge_beat_t it);
        int needed, nodes, accepted, best, ra, rb;
        bit found, ran_out;
        logic [COST_W-1:0] cost;
        tree_beat_t run_q[$];
        tree_beat_t t;
        if (it.op == OP_CLEAR)
        begin
            st_count = 0;
            uf_reset();
            return;
        end
        if (st_count < EDGE_SLOTS)
        begin
            st_a[st_count] = it.a;
            st_b[st_count] = it.b;
            st_w[st_count] = it.w;
            st_count++;
        end
        if (!it.fin)
            return;
        uf_reset();
        for (int i = 0; i < st_count; i++)
            st_used[i] = 1'b0;
        nodes = (tnc_shadow > NODES) ? NODES : tnc_shadow;
        needed = (nodes > 0) ? nodes - 1 : 0;
        accepted = 0;
        cost = '0;
        ran_out = 1'b0;
        while (accepted < needed)
        begin
            found = 1'b0;
            best = 0;
            for (int i = 0; i < st_count; i++)
                if (!st_used[i] && (!found || st_w[i] < st_w[best]))
                begin
                    best = i;
                    found = 1'b1;
                end
            if (!found)
            begin
                ran_out = 1'b1;
                break;
            end
            st_used[best] = 1'b1;
            ra = find_root(st_a[best]);
            rb = find_root(st_b[best]);
            if (ra == rb)
                continue;
            if (grp_size[ra] < grp_size[rb])
            begin
                link[ra] = rb;
                grp_size[rb] += grp_size[ra];
            end
            else
            begin
                link[rb] = ra;
                grp_size[ra] += grp_size[rb];
            end
            cost = cost + st_w[best];
            accepted++;
            t = '{1'b1, st_a[best], st_b[best], st_w[best], cost, 1'b0, 1'b0};
            run_q.insert(run_q.size(), t);
        end
        // empty tree still gives one beat
        if (run_q.size() == 0)
        begin
            t = '{1'b0, '0, '0, '0, '0, 1'b0, 1'b0};
            run_q.insert(run_q.size(), t);
        end
        run_q[run_q.size()-1].short_tree = ran_out;
        run_q[run_q.size()-1].last = 1'b1;
        foreach (run_q[i])
            tree_q.insert(tree_q.size(), run_q[i]);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Input driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (edge_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                edge_beat_t it;
                it = edge_q.pop_front();
                operation <= it.op;
                end_node_a <= it.a;
                end_node_b <= it.b;
                edge_weight <= it.w;
                final_edge <= it.fin;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall, with long hold-offs on request
    int hold_seen = 0;
    int hold_cnt = 0;
    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen++;
            hold_cnt = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Monitor: predict on input beats, check output beats
    always @(posedge clk)
    begin
        in_taken = rst_n && in_valid && !in_stall;
        if (in_taken)
            predict_tree('{operation, end_node_a, end_node_b, edge_weight, final_edge});
        if (rst_n && out_valid && !out_stall)
        begin
            if (tree_q.size() == 0)
            begin
                $error("unexpected tree beat");
                errors++;
            end
            else
            begin
                tree_beat_t e;
                e = tree_q.pop_front();
                check_field("edge_valid", e.valid, edge_valid);
                check_field("tree_node_a", e.a, tree_node_a);
                check_field("tree_node_b", e.b, tree_node_b);
                check_field("tree_weight", e.w, tree_weight);
                check_field("running_cost", e.cost, running_cost);
                check_field("incomplete", e.short_tree, incomplete);
                check_field("last_result", e.last, last_result);
            end
        end
    end

    // Watchdog on cycles with no beat on either channel
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_edge(logic op, int a, int b, int w, logic fin);
        edge_beat_t it;
        it = '{op, a[NODE_PORT_W-1:0], b[NODE_PORT_W-1:0], w[WEIGHT_PORT_W-1:0], fin};
        edge_q.insert(edge_q.size(), it);
    endtask

    task automatic drain();
        while (edge_q.size() > 0 || in_valid || tree_q.size() > 0)
            @(posedge clk);
        // clear/load beats give no result; let the block settle
        repeat (30) @(posedge clk);
    endtask

    task automatic write_tnc(int val);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 3'(REG_TREE_NODE_COUNT) * 3'd4;
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        tnc_shadow = val[TNC_W-1:0];
    endtask

    // One random graph: mostly clear + edges + final, sometimes noise
    task automatic random_graph(int n_edges);
        int span, kind;
        span = (tnc_shadow < 2) ? 2 : ((tnc_shadow > NODES) ? NODES : tnc_shadow);
        kind = $urandom_range(9);
        if (kind != 0)
            push_edge(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < n_edges; i++)
        begin
            int a, b, w;
            if ($urandom_range(9) < 8)
            begin
                a = $urandom_range(span - 1);
                b = $urandom_range(span - 1);
            end
            else
            begin
                a = $urandom_range(31);
                b = $urandom_range(31);
            end
            // ties on weight are common on purpose
            w = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(7);
            if (kind == 1 && i == n_edges / 2)
                push_edge(OP_CLEAR, 0, 0, 0, 1'b1);
            push_edge(OP_LOAD, a, b, w, i == n_edges - 1);
        end
    endtask

    // Stimulus sequence
    initial
    begin
        int tnc_pick [7];
        tnc_pick = '{32, 63, 0, 1, 2, 5, 12};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, cycle, self loop, ties, empty trees
        write_tnc(TNC_RESET);
        push_edge(OP_CLEAR, 31, 31, 65535, 1'b1);
        push_edge(OP_LOAD, 0, 1, 0, 1'b0);
        push_edge(OP_LOAD, 1, 2, 65535, 1'b0);
        push_edge(OP_LOAD, 2, 0, 5, 1'b0);
        push_edge(OP_LOAD, 31, 31, 7, 1'b0);
        push_edge(OP_LOAD, 3, 4, 5, 1'b0);
        push_edge(OP_LOAD, 0, 31, 65535, 1'b1);
        push_edge(OP_LOAD, 30, 29, 1, 1'b1);
        drain();
        write_tnc(0);
        push_edge(OP_LOAD, 5, 6, 9, 1'b1);
        drain();
        write_tnc(1);
        push_edge(OP_LOAD, 7, 8, 9, 1'b1);
        drain();
        write_tnc(3);
        push_edge(OP_CLEAR, 0, 0, 0, 1'b0);
        push_edge(OP_LOAD, 4, 4, 3, 1'b0);
        push_edge(OP_LOAD, 1, 1, 2, 1'b1);
        drain();
        write_tnc(2);
        push_edge(OP_LOAD, 10, 11, 100, 1'b1);
        drain();

        // Store full with the receiver held off: the block backs up
        write_tnc(63);
        hold_requests++;
        push_edge(OP_CLEAR, 0, 0, 0, 1'b0);
        for (int i = 0; i < EDGE_SLOTS + 3; i++)
            push_edge(OP_LOAD, $urandom_range(31), $urandom_range(31),
                      $urandom_range(65535), i == EDGE_SLOTS + 2);
        push_edge(OP_LOAD, 1, 2, 3, 1'b1);
        push_edge(OP_CLEAR, 0, 0, 0, 1'b0);
        drain();

        // Random graphs, three idling profiles
        for (int g = 0; g < 3; g++)
        begin
            send_idle_pct = (g == 0) ? 10 : ((g == 1) ? 51 : 0);
            recv_idle_pct = (g == 0) ? 51 : ((g == 1) ? 10 : 0);
            for (int c = 0; c < 3; c++)
            begin
                write_tnc((c == 0) ? 32 : tnc_pick[$urandom_range(6)]);
                if (g == 1 && c == 1)
                    hold_requests++;
                for (int k = 0; k < 3; k++)
                    random_graph($urandom_range(2, 8));
                drain();
            end
        end

        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
